/* hw/rtl/keyword_gated_text_filter_macros.svh */
// Assertion macros shared by the filter modules.
`ifndef KEYWORD_GATED_TEXT_FILTER_MACROS_SVH
`define KEYWORD_GATED_TEXT_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define KGTF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define KGTF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KGTF_ASSERT(label, prop)
`define KGTF_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hw/rtl/kgtf_pkg.sv */
package kgtf_pkg;

  // Characters with a meaning to the scanner
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Keyword storage: bytes per keyword, bytes per register, register width
  localparam int KEY_BYTES    = 16;
  localparam int REG_BYTES    = 8;
  localparam int REG_W        = 64;
  localparam int CFG_INDEX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_A_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_A_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_B_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_B_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_C_LOW  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_C_HIGH = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_KEYWORD_COUNT  = 3'd6;

  // Scanner phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CAPTURE,
    PH_RAW
  } phase_t;

  // One result from the scanner core
  typedef struct packed {
    logic [7:0] data;
    logic       emit;
    logic       done;
    logic       err;
  } result_t;

endpackage

/* hw/rtl/kgtf_matcher.sv */
module kgtf_matcher
  import kgtf_pkg::*;
#(
  parameter int MAX_WORD     = 16,
  parameter int NUM_KEYWORDS = 3,
  localparam int LW          = $clog2(MAX_WORD + 1)
) (
  input  logic [2*NUM_KEYWORDS-1:0][REG_W-1:0] keys,
  input  logic [1:0]                           keyword_count,
  input  logic [MAX_WORD-1:0][7:0]             word,
  output logic [LW-1:0]                        maxlen,
  output logic                                 hit
);

  localparam logic [1:0] NK = 2'(NUM_KEYWORDS);

  logic [NUM_KEYWORDS-1:0][MAX_WORD-1:0][7:0] kb;
  logic [NUM_KEYWORDS-1:0][LW-1:0]            klen;
  logic [NUM_KEYWORDS-1:0]                    kact;
  logic [NUM_KEYWORDS-1:0]                    kmatch;
  logic [MAX_WORD-1:0]                        wz;
  logic [MAX_WORD-1:0]                        zb;
  logic [1:0]                                 act;

  // Spread keyword registers into bytes; bytes past KEY_BYTES read zero
  for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_key
    for (genvar j = 0; j < MAX_WORD; j++) begin : g_byte
      if (j < KEY_BYTES) begin : g_reg
        localparam int R = 2 * k + j / REG_BYTES;
        localparam int B = j % REG_BYTES;
        assign kb[k][j] = keys[R][8*B +: 8];
      end else begin : g_zero
        assign kb[k][j] = 8'h00;
      end
    end
  end

  // Flag zero bytes of the word, and mark positions past its terminator
  for (genvar j = 0; j < MAX_WORD; j++) begin : g_wz
    assign wz[j] = (word[j] == 8'h00);
    if (j == 0) begin : g_first
      assign zb[j] = 1'b0;
    end else begin : g_rest
      assign zb[j] = |wz[j-1:0];
    end
  end

  // Clamp the keyword count
  assign act = (keyword_count > NK) ? NK : keyword_count;

  // Per keyword: length to first zero byte, and string compare
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      klen[k] = LW'(MAX_WORD);
      for (int j = MAX_WORD - 1; j >= 0; j--) begin
        if (kb[k][j] == 8'h00) begin
          klen[k] = LW'(j);
        end
      end
      kact[k]   = (2'(k) < act);
      kmatch[k] = 1'b1;
      for (int j = 0; j < MAX_WORD; j++) begin
        if (!zb[j] && (word[j] != kb[k][j])) begin
          kmatch[k] = 1'b0;
        end
      end
    end
  end

  // Longest active keyword and any active match
  always_comb begin
    maxlen = '0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (kact[k] && (klen[k] > maxlen)) begin
        maxlen = klen[k];
      end
    end
  end

  assign hit = |(kact & kmatch);

endmodule

/* hw/rtl/kgtf_core.sv */
`include "keyword_gated_text_filter_macros.svh"

module kgtf_core
  import kgtf_pkg::*;
#(
  parameter int MAX_WORD = 16,
  localparam int LW      = $clog2(MAX_WORD + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [7:0]               text_byte,
  input  logic                     final_byte,
  input  logic [LW-1:0]            maxlen,
  input  logic                     hit,
  output logic [MAX_WORD-1:0][7:0] word_next,
  output result_t                  result
);

  logic [MAX_WORD-1:0][7:0] word_store;
  logic [LW-1:0]            word_length;
  logic [LW-1:0]            word_length_next;
  phase_t                   scan_phase;
  phase_t                   scan_phase_next;
  logic                     block_active;
  logic                     block_active_next;
  logic                     comment_active;
  logic                     comment_active_next;
  logic [LW-1:0]            bytes_after_command;
  logic [LW-1:0]            bytes_after_command_next;
  logic                     command_seen;
  logic                     command_seen_next;

  logic       cmd_start;
  logic       finish;
  logic       emit;
  logic       text_emit;
  logic       text_comment;
  logic [LW-1:0] len_inc;
  logic [LW:0]   bac_plus;

  // Plain-text handling of the current byte
  always_comb begin
    text_emit = block_active && !comment_active && (text_byte != CH_PERCENT) &&
                (text_byte != CH_LBRACE) && (text_byte != CH_RBRACE);
    if (!block_active) begin
      text_comment = comment_active;
    end else if (comment_active) begin
      text_comment = (text_byte != CH_NEWLINE);
    end else begin
      text_comment = (text_byte == CH_PERCENT);
    end
  end

  assign len_inc = word_length + LW'(1);

  // Scanner next state
  always_comb begin
    word_next           = word_store;
    word_length_next    = word_length;
    scan_phase_next     = scan_phase;
    comment_active_next = comment_active;
    cmd_start           = 1'b0;
    finish              = 1'b0;
    emit                = 1'b0;
    unique case (scan_phase)
      PH_CAPTURE: begin
        if (text_byte == CH_LBRACE) begin
          finish          = 1'b1;
          scan_phase_next = PH_IDLE;
        end else begin
          if (word_length < LW'(MAX_WORD)) begin
            for (int j = 0; j < MAX_WORD; j++) begin
              if (LW'(j) == word_length) begin
                word_next[j] = text_byte;
              end
            end
            word_length_next = len_inc;
          end
          if (word_length_next >= maxlen) begin
            finish          = 1'b1;
            scan_phase_next = PH_RAW;
          end
        end
      end
      PH_RAW: begin
        scan_phase_next     = PH_IDLE;
        emit                = text_emit;
        comment_active_next = text_comment;
      end
      default: begin
        if (text_byte == CH_BACKSLASH) begin
          cmd_start        = 1'b1;
          word_next        = '0;
          word_length_next = '0;
          if (maxlen == '0) begin
            finish          = 1'b1;
            scan_phase_next = PH_RAW;
          end else begin
            scan_phase_next = PH_CAPTURE;
          end
        end else begin
          scan_phase_next     = PH_IDLE;
          emit                = text_emit;
          comment_active_next = text_comment;
        end
      end
    endcase
  end

  // Block flag, command tracking and trailing-byte count
  always_comb begin
    if (cmd_start) begin
      block_active_next = finish && hit;
    end else begin
      block_active_next = block_active || (finish && hit);
    end
    command_seen_next = command_seen || cmd_start;
    if (cmd_start) begin
      bytes_after_command_next = '0;
    end else if (command_seen && (bytes_after_command < LW'(MAX_WORD))) begin
      bytes_after_command_next = bytes_after_command + LW'(1);
    end else begin
      bytes_after_command_next = bytes_after_command;
    end
  end

  // Result for this byte
  assign bac_plus = {1'b0, bytes_after_command_next} + (LW + 1)'(1);

  always_comb begin
    result.data = emit ? text_byte : 8'h00;
    result.emit = emit;
    result.done = final_byte;
    result.err  = final_byte &&
                  ((maxlen == '0) ||
                   (command_seen_next && (bac_plus < {1'b0, maxlen})));
  end

  // Advance state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      word_store          <= '0;
      word_length         <= '0;
      scan_phase          <= PH_IDLE;
      block_active        <= 1'b0;
      comment_active      <= 1'b0;
      bytes_after_command <= '0;
      command_seen        <= 1'b0;
    end else if (advance) begin
      word_store          <= word_next;
      word_length         <= word_length_next;
      scan_phase          <= scan_phase_next;
      block_active        <= block_active_next;
      comment_active      <= comment_active_next;
      bytes_after_command <= bytes_after_command_next;
      command_seen        <= command_seen_next;
    end
  end

  `KGTF_ASSERT(a_word_length_bound, word_length <= LW'(MAX_WORD))
  `KGTF_ASSERT(a_trail_count_bound, bytes_after_command <= LW'(MAX_WORD))
  `KGTF_ASSERT(a_block_needs_command,
               !command_seen |-> (!block_active && (bytes_after_command == '0)))

endmodule

/* hw/rtl/keyword_gated_text_filter.sv */
// Channel  | Dir | Group                   | Contents
// s_axis   | in  | s_tvalid/tready/tdata   | tdata[7:0] text_byte, tlast final_byte
// m_axis   | out | m_tvalid/tready/tdata   | tdata[7:0] out_byte, tlast stream_done,
//          |     |                         | tuser[0] out_valid, tuser[1] format_error
// cfg      | in  | cfg_we/index/data       | keyword registers, keyword count
//
// Takes one byte per cycle unless m_tready stalls; byte and result registered.
// The keyword compare on the updated capture word sets the longest path.
// Synchronous rst clears scanner state, keyword registers and valid flags.
// With m_tready low the result holds; one more byte waits in the input register,
// then s_tready drops. A byte that yields no result still waits its turn.
`include "keyword_gated_text_filter_macros.svh"

module keyword_gated_text_filter
  import kgtf_pkg::*;
#(
  parameter int MAX_WORD     = 16,
  parameter int NUM_KEYWORDS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  // cfg
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] text_byte
  input  logic                   s_tlast,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // [7:0] out_byte
  output logic                   m_tlast,
  output logic [1:0]             m_tuser    // [0] out_valid, [1] format_error
);

  localparam int LW = $clog2(MAX_WORD + 1);

  logic [2*NUM_KEYWORDS-1:0][REG_W-1:0] keys;
  logic [1:0]                           keyword_count;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_free;
  logic       advance;

  logic [MAX_WORD-1:0][7:0] word_next;
  logic [LW-1:0]            maxlen;
  logic                     hit;
  result_t                  result;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      keys          <= '0;
      keyword_count <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < 2 * NUM_KEYWORDS; i++) begin
        if (cfg_index == CFG_INDEX_W'(i)) begin
          keys[i] <= cfg_data;
        end
      end
      if (cfg_index == REG_KEYWORD_COUNT) begin
        keyword_count <= cfg_data[1:0];
      end
    end
  end

  // Handshake between input register and result register
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  kgtf_matcher #(
    .MAX_WORD     (MAX_WORD),
    .NUM_KEYWORDS (NUM_KEYWORDS)
  ) u_matcher (
    .keys          (keys),
    .keyword_count (keyword_count),
    .word          (word_next),
    .maxlen        (maxlen),
    .hit           (hit)
  );

  kgtf_core #(
    .MAX_WORD (MAX_WORD)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .text_byte  (in_byte),
    .final_byte (in_last),
    .maxlen     (maxlen),
    .hit        (hit),
    .word_next  (word_next),
    .result     (result)
  );

  // Result register: load a transfer only for emitted or final bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && (result.emit || result.done);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= result.data;
      m_tlast <= result.done;
      m_tuser <= {result.err, result.emit};
    end
  end

  `KGTF_ASSERT(a_result_has_cause, m_tvalid |-> (m_tuser[0] || m_tlast))
  `KGTF_ASSERT(a_quiet_data_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
  `KGTF_ASSERT(a_error_only_at_end, (m_tvalid && m_tuser[1]) |-> m_tlast)

endmodule

/* sim/tb_top.sv */
import kgtf_pkg::*;

// Tracks the scanner state, predicts the results of every accepted byte and
// compares the results that leave the block against them in order.
class text_filter_scoreboard;
  localparam int WORD_MAX     = 16;
  localparam int KEY_SLOTS    = 3;
  localparam int REPORT_LIMIT = 10;

  // keyword registers as the block sees them
  logic [REG_W-1:0] key_reg [6];
  logic [1:0]       key_count;

  // scanner state
  logic [7:0] word_store [WORD_MAX];
  int         word_len;
  phase_t     scan_state;
  bit         block_on;
  bit         comment_on;
  int         after_cmd;
  bit         cmd_seen;

  result_t    pending_results [$];

  int bytes_taken;
  int results_checked;
  int bytes_emitted;
  int errors_flagged;
  int mismatches;

  function new();
    foreach (key_reg[i]) key_reg[i] = '0;
    key_count = '0;
    foreach (word_store[i]) word_store[i] = 8'h00;
    word_len        = 0;
    scan_state      = PH_IDLE;
    block_on        = 1'b0;
    comment_on      = 1'b0;
    after_cmd       = 0;
    cmd_seen        = 1'b0;
    bytes_taken     = 0;
    results_checked = 0;
    bytes_emitted   = 0;
    errors_flagged  = 0;
    mismatches      = 0;
  endfunction

  function void write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    if (idx <= REG_KEYWORD_C_HIGH) begin
      key_reg[idx] = val;
    end else if (idx == REG_KEYWORD_COUNT) begin
      key_count = val[1:0];
    end
  endfunction

  function int active_keys();
    int n;
    n = int'(key_count);
    return (n > KEY_SLOTS) ? KEY_SLOTS : n;
  endfunction

  function logic [7:0] key_char(int k, int j);
    if (k >= KEY_SLOTS || j >= KEY_BYTES) return 8'h00;
    if (j < REG_BYTES) return key_reg[2*k][8*j +: 8];
    return key_reg[2*k+1][8*(j-REG_BYTES) +: 8];
  endfunction

  // keyword ends at its first zero byte
  function int key_len(int k);
    for (int j = 0; j < WORD_MAX; j++)
      if (key_char(k, j) == 8'h00) return j;
    return WORD_MAX;
  endfunction

  function int longest_key();
    int m;
    m = 0;
    for (int k = 0; k < active_keys(); k++)
      if (key_len(k) > m) m = key_len(k);
    return m;
  endfunction

  // compare the captured word as a zero-terminated string
  function bit word_hits(int k);
    logic [7:0] w;
    for (int j = 0; j < WORD_MAX; j++) begin
      w = (j < word_len) ? word_store[j] : 8'h00;
      if (w != key_char(k, j)) return 1'b0;
      if (w == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function void close_word();
    for (int k = 0; k < active_keys(); k++)
      if (word_hits(k)) block_on = 1'b1;
  endfunction

  // block-mode text handling; returns 1 when the byte goes out
  function bit text_step(logic [7:0] b, output logic [7:0] emit);
    emit = 8'h00;
    if (!block_on) return 1'b0;
    if (comment_on) begin
      if (b == CH_NEWLINE) comment_on = 1'b0;
      return 1'b0;
    end
    if (b == CH_PERCENT) begin
      comment_on = 1'b1;
      return 1'b0;
    end
    if (b == CH_LBRACE || b == CH_RBRACE) return 1'b0;
    emit = b;
    return 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    int         maxlen;
    logic [7:0] emit;
    bit         valid;
    bit         cmd_start;
    result_t    r;
    maxlen    = longest_key();
    emit      = 8'h00;
    valid     = 1'b0;
    cmd_start = 1'b0;
    bytes_taken++;
    case (scan_state)
      PH_CAPTURE: begin
        if (b == CH_LBRACE) begin
          close_word();
          scan_state = PH_IDLE;
          valid = text_step(b, emit);
        end else begin
          if (word_len < WORD_MAX) begin
            word_store[word_len] = b;
            word_len++;
          end
          if (word_len >= maxlen) begin
            close_word();
            scan_state = PH_RAW;
          end
        end
      end
      PH_RAW: begin
        scan_state = PH_IDLE;
        valid = text_step(b, emit);
      end
      default: begin
        if (b == CH_BACKSLASH) begin
          cmd_start = 1'b1;
          block_on  = 1'b0;
          cmd_seen  = 1'b1;
          after_cmd = 0;
          foreach (word_store[i]) word_store[i] = 8'h00;
          word_len = 0;
          if (maxlen == 0) begin
            close_word();
            scan_state = PH_RAW;
          end else begin
            scan_state = PH_CAPTURE;
          end
        end else begin
          scan_state = PH_IDLE;
          valid = text_step(b, emit);
        end
      end
    endcase

    if (!cmd_start && cmd_seen && after_cmd < WORD_MAX) after_cmd++;

    if (valid || last) begin
      r.data = valid ? emit : 8'h00;
      r.emit = valid;
      r.done = last;
      r.err  = last && (maxlen == 0 || (cmd_seen && after_cmd + 1 < maxlen));
      pending_results.push_back(r);
    end
  endfunction

  function void check_output(logic [7:0] data, logic last, logic [1:0] user);
    result_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected result: data %02h done %0b valid %0b error %0b",
                 data, last, user[0], user[1]);
      return;
    end
    want = pending_results.pop_front();
    if (want.emit) bytes_emitted++;
    if (want.err) errors_flagged++;
    if (data !== want.data || user[0] !== want.emit || last !== want.done ||
        user[1] !== want.err) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch: want data %02h v %0b d %0b e %0b, got %02h v %0b d %0b e %0b",
                 want.data, want.emit, want.done, want.err,
                 data, user[0], last, user[1]);
    end
  endfunction

  function void flag_leftover();
    if (pending_results.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_results.size());
    end
  endfunction

  function int pending_count();
    return pending_results.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 180;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = 8'h00;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [7:0]             m_tdata;
  logic                   m_tlast;
  logic [1:0]             m_tuser;

  text_filter_scoreboard sb;

  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int last_pct      = 3;
  int items_driven  = 0;
  int settings_used = 0;

  keyword_gated_text_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one window in four runs without any idling
  function bit quiet_window();
    return cycle_count[8:7] == 2'b11;
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= quiet_window() || ($urandom_range(99) >= recv_idle_pct);
  end

  // observe both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tlast, m_tuser);
    end
  end

  function automatic logic [127:0] key_from_string(string s);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < KEY_BYTES; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // keyword of len bytes, zero after it, optional junk beyond the zero
  function automatic logic [127:0] make_key(int len, bit junk_tail);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < len)
        v[8*i +: 8] = ($urandom_range(99) < 80) ? 8'($urandom_range(8'h7A, 8'h61))
                                                : 8'($urandom_range(255, 1));
      else if (i > len && junk_tail)
        v[8*i +: 8] = 8'($urandom_range(255));
    end
    return v;
  endfunction

  // count register value with random upper bits
  function automatic logic [REG_W-1:0] count_word(int n);
    logic [REG_W-1:0] v;
    v = {$urandom, $urandom};
    v[1:0] = 2'(n);
    return v;
  endfunction

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
  endtask

  // write every register, then drop the enable
  task automatic configure(logic [127:0] ka, logic [127:0] kb, logic [127:0] kc,
                           logic [REG_W-1:0] cnt);
    write_reg(REG_KEYWORD_A_LOW,  ka[63:0]);
    write_reg(REG_KEYWORD_A_HIGH, ka[127:64]);
    write_reg(REG_KEYWORD_B_LOW,  kb[63:0]);
    write_reg(REG_KEYWORD_B_HIGH, kb[127:64]);
    write_reg(REG_KEYWORD_C_LOW,  kc[63:0]);
    write_reg(REG_KEYWORD_C_HIGH, kc[127:64]);
    write_reg(REG_KEYWORD_COUNT,  cnt);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // hold valid until the transfer, idling first at random
  task automatic drive_byte(logic [7:0] b, logic last);
    while (!quiet_window() && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_driven++;
  endtask

  task automatic send_item(logic [7:0] b);
    drive_byte(b, $urandom_range(99) < last_pct);
  endtask

  task automatic send_string(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      drive_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // backslash, a keyword in use, and a brace if the keyword is short
  task automatic send_command();
    int n;
    int m;
    int k;
    int len;
    n = sb.active_keys();
    m = sb.longest_key();
    send_item(CH_BACKSLASH);
    if (m == 0) return;
    k   = $urandom_range(n - 1);
    len = sb.key_len(k);
    for (int j = 0; j < len; j++) send_item(sb.key_char(k, j));
    if (len < m) send_item(CH_LBRACE);
  endtask

  // commands close to a keyword: altered, cut short, ended by a zero byte, or random
  task automatic send_broken();
    int         m;
    int         k;
    int         len;
    int         variant;
    int         pos;
    logic [7:0] c;
    m = sb.longest_key();
    send_item(CH_BACKSLASH);
    if (m == 0) return;
    k       = $urandom_range(sb.active_keys() - 1);
    len     = sb.key_len(k);
    variant = (len == 0) ? 3 : $urandom_range(3);
    case (variant)
      0: begin
        pos = $urandom_range(len - 1);
        for (int j = 0; j < len; j++) begin
          c = sb.key_char(k, j);
          if (j == pos) c ^= 8'(1 << $urandom_range(7));
          send_item(c);
        end
        if (len < m) send_item(CH_LBRACE);
      end
      1: begin
        for (int j = 0; j < len - 1; j++) send_item(sb.key_char(k, j));
        send_item(CH_LBRACE);
      end
      2: begin
        // zero byte inside the capture, junk after it
        for (int j = 0; j < len; j++) send_item(sb.key_char(k, j));
        send_item(8'h00);
        for (int j = len + 1; j < m; j++) send_item(8'($urandom_range(255)));
      end
      default: begin
        pos = $urandom_range(m + 1);
        for (int j = 0; j < pos; j++) send_item(8'($urandom_range(255)));
      end
    endcase
  endtask

  // block text rich in comments, braces and newlines
  task automatic send_body();
    int len;
    int r;
    len = $urandom_range(16, 2);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 55)      send_item(8'($urandom_range(8'h7E, 8'h20)));
      else if (r < 65) send_item(CH_PERCENT);
      else if (r < 77) send_item(CH_NEWLINE);
      else if (r < 83) send_item(CH_LBRACE);
      else if (r < 89) send_item(CH_RBRACE);
      else if (r < 97) send_item(8'($urandom_range(255)));
      else             send_item(CH_BACKSLASH);
    end
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(8, 1);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)));
  endtask

  task automatic run_random(int count);
    int target;
    int r;
    target = items_driven + count;
    while (items_driven < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_command();
        send_body();
      end else if (r < 70) begin
        send_broken();
        send_body();
      end else if (r < 85) begin
        send_noise();
      end else begin
        send_body();
      end
    end
    // leave a capture open across the next register change
    drive_byte(CH_BACKSLASH, 1'b0);
    drive_byte(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
  endtask

  // stop sending until every expected result is out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two short keywords and one of eight bytes
    set_idle(7, 86);
    configure(key_from_string("cd"), key_from_string("vb"),
              key_from_string("longword"), count_word(3));
    send_string("a", 1'b0);
    send_string("\\cd{", 1'b0);
    send_string("x%}\n{}", 1'b0);
    drive_byte(8'h00, 1'b0);
    drive_byte(8'hFF, 1'b0);
    send_string("\\longword\\", 1'b0);
    send_string("\\vb", 1'b1);
    run_random(100);
    settle();

    // one short keyword in use
    configure(make_key($urandom_range(8, 1), 1'b0), make_key(16, 1'b1),
              make_key($urandom_range(16, 1), 1'b1), count_word(1));
    run_random(RANDOM_ITEMS);
    settle();

    // empty keywords: zero maxlen, the empty word matches
    configure(128'd0, make_key(0, 1'b1), '1, count_word(2));
    run_random(RANDOM_ITEMS);
    settle();

    // all ones: three identical keywords of full length
    set_idle(86, 7);
    configure('1, '1, '1, '1);
    run_random(RANDOM_ITEMS);
    settle();

    // three keywords with junk after their terminating zero
    configure(make_key($urandom_range(16, 1), 1'b1), make_key($urandom_range(16, 1), 1'b1),
              make_key($urandom_range(16, 1), 1'b1), count_word(3));
    run_random(RANDOM_ITEMS);
    settle();

    // all zero, no keywords: only end-of-text results, so end often
    set_idle(0, 0);
    last_pct = 25;
    configure(128'd0, 128'd0, 128'd0, 64'd0);
    run_random(RANDOM_ITEMS);
    settle();
    last_pct = 3;

    // two keywords in use
    configure(make_key($urandom_range(12, 1), 1'b0), make_key($urandom_range(12, 1), 1'b0),
              make_key($urandom_range(12, 1), 1'b0), count_word(2));
    run_random(RANDOM_ITEMS);
    settle();

    sb.flag_leftover();
    $display("covered %0d bytes over %0d keyword settings with three stall patterns",
             sb.bytes_taken, settings_used);
    $display("checked %0d results: %0d bytes emitted, %0d format errors",
             sb.results_checked, sb.bytes_emitted, sb.errors_flagged);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
